// ===== src/jdst_pkg.sv =====
// Package for the Julian date and sidereal angle clock.
// Holds payload structs, unit request types, state codes and fixed-point constants.
// No dependencies.
package jdst_pkg;

  localparam int unsigned DIV_W   = 144;
  localparam int unsigned DEN_W   = 57;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 48;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned LON_W   = 33;
  localparam int unsigned HORN_STEPS = 5;

  typedef struct packed {
    logic               operation;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [11:0]        year;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [15:0]        second_ms;
    logic signed [31:0] step_ms;
  } jdst_in_t;

  typedef struct packed {
    logic [63:0]        julian_date;
    logic signed [63:0] days_since_j2000;
    logic signed [63:0] centuries_since_j2000;
    logic signed [63:0] years_since_j2000;
    logic [31:0]        sidereal_angle;
  } jdst_out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] word;
    logic [DEN_W-1:0] den;
    logic [CNT_W-1:0] n;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] p;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CDIV,
    ST_FRAC,
    ST_CENT,
    ST_YEAR,
    ST_FMUL,
    ST_FDIV,
    ST_HORN,
    ST_PDIV,
    ST_LDIV,
    ST_OUT
  } jdst_state_e;

  // floor(num * 2^extra / den) mod 2^64, elaboration only
  function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den,
                                            int unsigned extra);
    logic [64:0] rem;
    logic [63:0] q;
    logic [63:0] sh;
    int unsigned i;
    rem = '0;
    q   = '0;
    sh  = num;
    for (i = 0; i < 64 + extra; i++) begin
      rem = {rem[63:0], sh[63]};
      sh  = {sh[62:0], 1'b0};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [63:0] J2000_RAW = {32'd2451545, 32'd0};
  localparam logic [63:0] ERA_K0    = const_div(64'd7790572732640, 64'd10000000000000, 64);
  localparam logic [47:0] ERA_RATE  = 48'd273781191135448;
  localparam logic [63:0] HORN_INIT = 64'd0 - const_div(64'd368, 64'd10000000000, 40);
  localparam logic [63:0] HA0 = 64'd0 - const_div(64'd29956, 64'd1000000000, 40);
  localparam logic [63:0] HA1 = 64'd0 - const_div(64'd44, 64'd100000000, 40);
  localparam logic [63:0] HA2 = const_div(64'd13915817, 64'd10000000, 40);
  localparam logic [63:0] HA3 = const_div(64'd4612156534, 64'd1000000, 40);
  localparam logic [63:0] HA4 = const_div(64'd14506, 64'd1000000, 40);
  localparam logic [63:0] CENT_SAT = 64'd36525 << 47;
  localparam logic [63:0] YEAR_SAT = 64'd1461 << 45;
  localparam logic [63:0] POLY_LIM = 64'd1 << 55;

  localparam logic [DEN_W-1:0] DEN_CENTURY = 57'd100;
  localparam logic [DEN_W-1:0] DEN_DAY_MS  = 57'd86400000;
  localparam logic [DEN_W-1:0] DEN_JCENT   = 57'd36525;
  localparam logic [DEN_W-1:0] DEN_4YEAR   = 57'd1461;
  localparam logic [DEN_W-1:0] DEN_ERA     = 57'd100000000000000000;
  localparam logic [DEN_W-1:0] DEN_ARCSEC  = 57'd1296000;
  localparam logic [DEN_W-1:0] DEN_DEG     = 57'd360;

  function automatic logic [63:0] horn_add(logic [2:0] k);
    logic [63:0] r;
    case (k)
      3'd0:    r = HA0;
      3'd1:    r = HA1;
      3'd2:    r = HA2;
      3'd3:    r = HA3;
      3'd4:    r = HA4;
      default: r = '0;
    endcase
    return r;
  endfunction

  // floor(30.6001 * (mm + 1))
  function automatic logic [8:0] month_days(logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd30;
      4'd1:    r = 9'd61;
      4'd2:    r = 9'd91;
      4'd3:    r = 9'd122;
      4'd4:    r = 9'd153;
      4'd5:    r = 9'd183;
      4'd6:    r = 9'd214;
      4'd7:    r = 9'd244;
      4'd8:    r = 9'd275;
      4'd9:    r = 9'd306;
      4'd10:   r = 9'd336;
      4'd11:   r = 9'd367;
      4'd12:   r = 9'd397;
      4'd13:   r = 9'd428;
      4'd14:   r = 9'd459;
      default: r = 9'd489;
    endcase
    return r;
  endfunction

endpackage

// ===== src/jdst_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on jdst_pkg for request and response types.
module jdst_div import jdst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0] word_q, word_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [63:0]      quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, word_q[DIV_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    word_d = word_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      word_d = req_i.word;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = req_i.n;
      busy_d = 1'b1;
    end else if (busy_q) begin
      word_d = {word_q[DIV_W-2:0], 1'b0};
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d  = {quo_q[62:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule

// ===== src/jdst_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on jdst_pkg for request and response types.
module jdst_mul import jdst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int unsigned MC_W = $clog2(MUL_B_W + 1);

  logic [MUL_P_W-1:0] p_q, p_d;
  logic [MUL_A_W-1:0] a_q, a_d;
  logic [MC_W-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [MUL_A_W:0]   upper;

  always_comb begin
    upper  = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d    = p_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      p_d    = {{MUL_A_W{1'b0}}, req_i.b};
      a_d    = req_i.a;
      cnt_d  = MC_W'(MUL_B_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {upper, p_q[MUL_B_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule

// ===== src/julian_date_sidereal_time_clock.sv =====
// Julian date and local sidereal angle clock. Each item (a calendar set or a
// millisecond step) yields one result: the Julian date, offsets from J2000 and
// the local sidereal angle. One item is in work at a time. The bit-serial divider
// runs seven divisions for a set and six for an advance, and the bit-serial
// multiplier forms six products. A finished result waits in the output register
// while the next item is accepted. Longitude is written on its own channel; the
// user must write it only while the block is idle, and the block itself does
// not enforce this.
// Depends on jdst_pkg, jdst_div and jdst_mul.
module julian_date_sidereal_time_clock import jdst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jdst_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jdst_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LON_W-1:0] cfg_data_i
);

  jdst_state_e state_q, state_d;
  jdst_in_t    item_q;
  logic [LON_W-1:0] lon_q;
  logic [63:0] jd_q, jd_d;
  logic [63:0] cent_q, cent_d;
  logic [63:0] years_q, years_d;
  logic [63:0] sum_q, sum_d;
  logic [63:0] acc_q, acc_d;
  logic [5:0]  c_q, c_d;
  logic [2:0]  k_q, k_d;
  logic        go_q, go_d;
  jdst_out_t   out_q;
  logic        out_valid_q;
  logic        out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     unit_done;
  logic     in_acc;

  logic        adj;
  logic [11:0] a_div;
  logic [13:0] ax;
  logic [24:0] ay;
  logic [31:0] whole;
  logic [31:0] ms;
  logic [63:0] set_num;
  logic [31:0] step_mag;
  logic [63:0] adv_num;
  logic [63:0] days, dmag, amag, cmag, cclamp, q_neg, r_mul;
  logic [LON_W-1:0] lmag;
  logic [MUL_B_W-1:0] t_mag;
  logic        dneg, aneg, cneg, lneg;

  jdst_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  jdst_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign unit_done   = div_rsp.done || mul_rsp.done;

  always_comb begin
    adj      = (item_q.month == 4'd1) || (item_q.month == 4'd2);
    a_div    = (adj && item_q.year == 12'd0) ? 12'd0 : item_q.year - {11'd0, adj};
    ax       = {2'b00, item_q.year} + 14'd4716 - {13'd0, adj};
    ay       = 25'(ax) * 25'd1461;
    whole    = 32'(ay[24:2]) + 32'(month_days(item_q.month + (adj ? 4'd12 : 4'd0)))
               + 32'(item_q.day) + 32'd2 + 32'(c_q[5:2]) - 32'(c_q) - 32'd1525;
    ms       = 32'(item_q.hour) * 32'd3600000 + 32'(item_q.minute) * 32'd60000
               + 32'(item_q.second_ms);
    set_num  = {ms, 32'd0} + 64'd43200000;
    step_mag = item_q.step_ms[31] ? 32'd0 - item_q.step_ms : item_q.step_ms;
    adv_num  = {step_mag, 32'd0} + 64'd43200000;
    days     = jd_q - J2000_RAW;
    dneg     = days[63];
    dmag     = dneg ? 64'd0 - days : days;
    aneg     = acc_q[63];
    amag     = aneg ? 64'd0 - acc_q : acc_q;
    cneg     = cent_q[63];
    cmag     = cneg ? 64'd0 - cent_q : cent_q;
    cclamp   = (cmag > POLY_LIM) ? POLY_LIM : cmag;
    t_mag    = cclamp[55:8];
    lneg     = lon_q[LON_W-1];
    lmag     = lneg ? {LON_W{1'b0}} - lon_q : lon_q;
    q_neg    = 64'd0 - div_rsp.q;
    r_mul    = mul_rsp.p[103:40];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = in_data_i.operation ? ST_FRAC : ST_CDIV;
      ST_CDIV: if (unit_done) state_d = ST_FRAC;
      ST_FRAC: if (unit_done) state_d = ST_CENT;
      ST_CENT: if (unit_done) state_d = ST_YEAR;
      ST_YEAR: if (unit_done) state_d = ST_FMUL;
      ST_FMUL: if (unit_done) state_d = ST_FDIV;
      ST_FDIV: if (unit_done) state_d = ST_HORN;
      ST_HORN: if (unit_done && k_q == 3'(HORN_STEPS - 1)) state_d = ST_PDIV;
      ST_PDIV: if (unit_done) state_d = ST_LDIV;
      ST_LDIV: if (unit_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_req       = '0;
    mul_req       = '0;
    go_d          = go_q;
    jd_d          = jd_q;
    cent_d        = cent_q;
    years_d       = years_q;
    sum_d         = sum_q;
    acc_d         = acc_q;
    c_d           = c_q;
    k_d           = k_q;
    div_req.start = 1'b0;
    unique case (state_q)
      ST_CDIV: begin
        div_req.word = {a_div, 132'd0};
        div_req.den  = DEN_CENTURY;
        div_req.n    = CNT_W'(12);
      end
      ST_FRAC: begin
        div_req.word = {item_q.operation ? adv_num : set_num, 80'd0};
        div_req.den  = DEN_DAY_MS;
        div_req.n    = CNT_W'(64);
      end
      ST_CENT: begin
        div_req.word = {dmag, 80'd0};
        div_req.den  = DEN_JCENT;
        div_req.n    = CNT_W'(80);
      end
      ST_YEAR: begin
        div_req.word = {dmag, 80'd0};
        div_req.den  = DEN_4YEAR;
        div_req.n    = CNT_W'(82);
      end
      ST_FMUL: begin
        mul_req.a = dmag;
        mul_req.b = ERA_RATE;
      end
      ST_FDIV: begin
        div_req.word = {mul_rsp.p, 32'd0};
        div_req.den  = DEN_ERA;
        div_req.n    = CNT_W'(144);
      end
      ST_HORN: begin
        mul_req.a = amag;
        mul_req.b = t_mag;
      end
      ST_PDIV: begin
        div_req.word = {amag, 80'd0};
        div_req.den  = DEN_ARCSEC;
        div_req.n    = CNT_W'(88);
      end
      ST_LDIV: begin
        div_req.word = {lmag, 111'd0};
        div_req.den  = DEN_DEG;
        div_req.n    = CNT_W'(73);
      end
      default: ;
    endcase

    if (state_q != ST_IDLE && state_q != ST_OUT) begin
      if (!go_q) begin
        go_d = 1'b1;
        if (state_q == ST_FMUL || state_q == ST_HORN) mul_req.start = 1'b1;
        else div_req.start = 1'b1;
      end else if (unit_done) begin
        go_d = 1'b0;
      end
    end

    if (unit_done) begin
      unique case (state_q)
        ST_CDIV: c_d = div_rsp.q[5:0];
        ST_FRAC: begin
          if (!item_q.operation) jd_d = {whole, 32'h8000_0000} + div_rsp.q;
          else if (item_q.step_ms[31]) jd_d = jd_q - div_rsp.q;
          else jd_d = jd_q + div_rsp.q;
        end
        ST_CENT: begin
          if (dmag >= CENT_SAT) cent_d = dneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          else cent_d = dneg ? q_neg : div_rsp.q;
          sum_d = ERA_K0 + {days[31:0], 32'd0};
        end
        ST_YEAR: begin
          if (dmag >= YEAR_SAT) years_d = dneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          else years_d = dneg ? q_neg : div_rsp.q;
        end
        ST_FDIV: begin
          sum_d = sum_q + (dneg ? q_neg : div_rsp.q);
          acc_d = HORN_INIT;
          k_d   = '0;
        end
        ST_HORN: begin
          acc_d = ((aneg ^ cneg) ? 64'd0 - r_mul : r_mul) + horn_add(k_q);
          k_d   = k_q + 3'd1;
        end
        ST_PDIV: sum_d = sum_q + (aneg ? q_neg : div_rsp.q);
        ST_LDIV: sum_d = sum_q + (lneg ? q_neg : div_rsp.q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      jd_q        <= J2000_RAW;
      lon_q       <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      k_q     <= k_d;
      jd_q    <= jd_d;
      if (cfg_valid_i) lon_q <= cfg_data_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    cent_q  <= cent_d;
    years_q <= years_d;
    sum_q   <= sum_d;
    acc_q   <= acc_d;
    c_q     <= c_d;
    if (out_load) begin
      out_q.julian_date           <= jd_q;
      out_q.days_since_j2000      <= days;
      out_q.centuries_since_j2000 <= cent_q;
      out_q.years_since_j2000     <= years_q;
      out_q.sidereal_angle        <= 32'((sum_q + 64'h8000_0000) >> 32);
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("block still ready after taking an item");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> state_q == ST_OUT)
    else $error("result left while output register full");

  a_go_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> (state_q != ST_IDLE && state_q != ST_OUT))
    else $error("unit in flight outside a unit state");

  a_horn_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HORN |-> k_q < 3'(HORN_STEPS))
    else $error("Horner step count overran");
`endif

endmodule
